@@ rtl/tccw_pkg.sv @@
package tccw_pkg;

	// Screen geometry defaults
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Field widths
	localparam int CHAR_W = 8;
	localparam int RROW_W = 5;
	localparam int RCOL_W = 7;
	localparam int POS_W  = 11;

	// Special character codes
	localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

	// Request function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
		logic [RROW_W-1:0] read_row;
		logic [RCOL_W-1:0] read_col;
	} req_word_t;

	typedef struct packed {
		logic              cursor_update;
		logic [POS_W-1:0]  cursor_pos;
		logic              scrolled;
		logic              refresh_display;
		logic [CHAR_W-1:0] read_char;
	} rsp_word_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_NEWLINE,
		OP_PRINT,
		OP_READ
	} op_t;

	// Classified word as it travels through the queue
	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              rd_ok;
		logic [RROW_W-1:0] rrow;
		logic [RCOL_W-1:0] rcol;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCROLL,
		ST_ADDR,
		ST_MEM,
		ST_DONE
	} state_t;

endpackage

@@ rtl/tccw_front.sv @@
module tccw_front #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  logic                req_valid,
	output logic                req_stall,
	input  tccw_pkg::req_word_t req,
	input  logic                q_full,
	output logic                q_push,
	output tccw_pkg::entry_t    q_entry
);

	// Accept a word whenever the queue has room
	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	// Classify the word and check the read cell against the screen
	always_comb begin
		q_entry.ch    = req.char_code;
		q_entry.last  = req.last_char;
		q_entry.rrow  = req.read_row;
		q_entry.rcol  = req.read_col;
		q_entry.rd_ok = (32'(req.read_row) < 32'(ROWS)) && (32'(req.read_col) < 32'(COLUMNS));
		if (req.func == tccw_pkg::FUNC_READ) begin
			q_entry.op = tccw_pkg::OP_READ;
		end else if (req.char_code == tccw_pkg::CHAR_NUL) begin
			q_entry.op = tccw_pkg::OP_NOP;
		end else if (req.char_code == tccw_pkg::CHAR_NEWLINE) begin
			q_entry.op = tccw_pkg::OP_NEWLINE;
		end else begin
			q_entry.op = tccw_pkg::OP_PRINT;
		end
	end

endmodule

@@ rtl/tccw_fifo.sv @@
module tccw_fifo #(
	parameter int DEPTH = tccw_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tccw_pkg::entry_t push_entry,
	input  logic             pop,
	output tccw_pkg::entry_t head,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tccw_pkg::entry_t  slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/tccw_back.sv @@
module tccw_back #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tccw_pkg::entry_t    head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output tccw_pkg::rsp_word_t rsp
);

	localparam int ROW_W  = $clog2(ROWS + 1);
	localparam int PHYS_W = $clog2(ROWS);
	localparam int CCOL_W = $clog2(COLUMNS);
	localparam int FILL_W = $clog2(COLUMNS + 1);
	localparam int ADDR_W = $clog2(ROWS * COLUMNS);
	localparam int CPOS_W = $clog2(ROWS * COLUMNS + 1);

	tccw_pkg::state_t    state_q;
	tccw_pkg::state_t    state_d;
	tccw_pkg::entry_t    cur_q;
	tccw_pkg::rsp_word_t out_q;
	logic                out_valid_q;

	logic [PHYS_W-1:0]   base_q;
	logic [ROW_W-1:0]    crow_q;
	logic [CCOL_W-1:0]   ccol_q;
	logic [FILL_W-1:0]   fill_q [ROWS];
	logic [7:0]          mem [ROWS * COLUMNS];

	logic [ADDR_W-1:0]   addr_q;
	logic [PHYS_W-1:0]   phys_q;
	logic [7:0]          rdata_q;
	logic                rdok_q;
	logic                scr_q;

	logic                out_free;
	logic                ld_cur;
	logic                ld_out;
	logic                in_scroll;
	logic                in_addr;
	logic                in_mem;
	logic                scroll_en;

	logic [ROW_W-1:0]    row_sel;
	logic [CCOL_W-1:0]   col_sel;
	logic [ROW_W:0]      row_sum;
	logic [PHYS_W-1:0]   phys;
	logic [CPOS_W-1:0]   cpos;

	assign out_free = !out_valid_q || !rsp_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tccw_pkg::ST_IDLE: begin
				if (!q_empty) begin
					state_d = tccw_pkg::ST_SCROLL;
				end
			end
			tccw_pkg::ST_SCROLL: state_d = tccw_pkg::ST_ADDR;
			tccw_pkg::ST_ADDR:   state_d = tccw_pkg::ST_MEM;
			tccw_pkg::ST_MEM:    state_d = tccw_pkg::ST_DONE;
			tccw_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = q_empty ? tccw_pkg::ST_IDLE : tccw_pkg::ST_SCROLL;
				end
			end
			default: state_d = tccw_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		ld_cur    = 1'b0;
		ld_out    = 1'b0;
		in_scroll = 1'b0;
		in_addr   = 1'b0;
		in_mem    = 1'b0;
		unique case (state_q)
			tccw_pkg::ST_IDLE:   ld_cur = !q_empty;
			tccw_pkg::ST_SCROLL: in_scroll = 1'b1;
			tccw_pkg::ST_ADDR:   in_addr = 1'b1;
			tccw_pkg::ST_MEM:    in_mem = 1'b1;
			tccw_pkg::ST_DONE: begin
				ld_out = out_free;
				ld_cur = out_free && !q_empty;
			end
			default: ;
		endcase
	end

	assign q_pop = ld_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tccw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the word under execution
	always_ff @(posedge clk) begin
		if (ld_cur) begin
			cur_q <= head;
		end
	end

	// Scroll is due when a character arrives with the row index past the bottom
	assign scroll_en = (cur_q.op == tccw_pkg::OP_PRINT || cur_q.op == tccw_pkg::OP_NEWLINE)
		&& (crow_q == ROW_W'(ROWS));

	// Map the logical row onto the rotating row ring
	always_comb begin
		if (cur_q.op == tccw_pkg::OP_READ) begin
			row_sel = cur_q.rd_ok ? ROW_W'(cur_q.rrow) : '0;
			col_sel = cur_q.rd_ok ? CCOL_W'(cur_q.rcol) : '0;
		end else begin
			row_sel = crow_q;
			col_sel = ccol_q;
		end
		row_sum = (ROW_W + 1)'(base_q) + (ROW_W + 1)'(row_sel);
		if (row_sum >= (ROW_W + 1)'(ROWS)) begin
			phys = PHYS_W'(row_sum - (ROW_W + 1)'(ROWS));
		end else begin
			phys = PHYS_W'(row_sum);
		end
	end

	// Register the cell address
	always_ff @(posedge clk) begin
		if (in_addr) begin
			phys_q <= phys;
			addr_q <= ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
		end
	end

	// Screen memory: at most one write or one read per item
	always_ff @(posedge clk) begin
		if (in_mem && cur_q.op == tccw_pkg::OP_PRINT) begin
			mem[addr_q] <= cur_q.ch;
		end
		if (in_mem && cur_q.op == tccw_pkg::OP_READ) begin
			rdata_q <= mem[addr_q];
		end
	end

	// Cells at or beyond a row's fill count read as blank
	always_ff @(posedge clk) begin
		if (in_mem) begin
			rdok_q <= cur_q.rd_ok && (FILL_W'(col_sel) < fill_q[phys_q]);
		end
		if (in_scroll) begin
			scr_q <= scroll_en;
		end
	end

	// Cursor, row ring and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			crow_q <= '0;
			ccol_q <= '0;
			for (int i = 0; i < ROWS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (in_scroll && scroll_en) begin
				base_q         <= (base_q == PHYS_W'(ROWS - 1)) ? '0 : base_q + 1'b1;
				fill_q[base_q] <= '0;
				crow_q         <= ROW_W'(ROWS - 1);
			end
			if (in_mem && cur_q.op == tccw_pkg::OP_NEWLINE) begin
				crow_q <= crow_q + 1'b1;
				ccol_q <= '0;
			end
			if (in_mem && cur_q.op == tccw_pkg::OP_PRINT) begin
				fill_q[phys_q] <= FILL_W'(ccol_q) + 1'b1;
				if (ccol_q == CCOL_W'(COLUMNS - 1)) begin
					crow_q <= crow_q + 1'b1;
					ccol_q <= '0;
				end else begin
					ccol_q <= ccol_q + 1'b1;
				end
			end
		end
	end

	// Build the response word
	assign cpos = CPOS_W'(crow_q) * CPOS_W'(COLUMNS) + CPOS_W'(ccol_q);

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_q.cursor_update   <= (cur_q.op == tccw_pkg::OP_PRINT);
			out_q.cursor_pos      <= tccw_pkg::POS_W'(cpos);
			out_q.scrolled        <= scr_q;
			out_q.refresh_display <= (cur_q.op != tccw_pkg::OP_READ) && cur_q.last;
			out_q.read_char       <= (cur_q.op == tccw_pkg::OP_READ && rdok_q) ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

@@ rtl/text_console_char_writer.sv @@
// Teletype character writer for a COLUMNS x ROWS text screen.
// Request channel (req_valid/req_stall/req): each word either writes one
// character at the cursor (func = 0) or reads one screen cell (func = 1).
// Character 0 is ignored, newline moves to column 0 of the next row, and a
// character written with the row index past the bottom scrolls the screen
// up one row first. Response channel (rsp_valid/rsp_stall/rsp): exactly one
// word per request, in order, with the cursor position after the request.
// The back-end sequencer steps one request at a time through its scroll,
// address, memory access and response states, and waits in the response
// state while the response register is held by rsp_stall.
// Scrolling rotates a row base pointer and zeroes the row's fill count, so it
// moves no screen data. A two-word queue lets requests be accepted while the
// back end works; req_stall rises only when that queue is full.
// When rsp_stall is high the response register holds its word and the back
// end waits with the next result; the queue keeps taking requests.
// Reset clears the cursor, the row base and all fill counts, so the whole
// screen reads as blank at once; no clearing pass is needed.
module text_console_char_writer #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  tccw_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output tccw_pkg::rsp_word_t rsp
);

	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	tccw_pkg::entry_t q_entry;
	tccw_pkg::entry_t q_head;

	tccw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	tccw_fifo #(
		.DEPTH(tccw_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_entry),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	tccw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

@@ rtl/tccw_checker.sv @@
module tccw_checker #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input tccw_pkg::rsp_word_t rsp
);

	localparam int BOTTOM_W = $clog2(ROWS * COLUMNS + 1);
	localparam logic [BOTTOM_W-1:0] BOTTOM_START = BOTTOM_W'((ROWS - 1) * COLUMNS);

	// A stalled response word stays valid
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	// A stalled response word keeps its value
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("response changed while stalled");

	// A scroll leaves the cursor on the bottom row or just past it
	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.scrolled |-> BOTTOM_W'(rsp.cursor_pos) >= BOTTOM_START)
		else $error("scroll left cursor above bottom row");

	// A stored character moves the cursor off home and reads nothing back
	a_print_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.cursor_update |-> rsp.cursor_pos != '0 && rsp.read_char == '0)
		else $error("bad response for a stored character");

endmodule

bind text_console_char_writer tccw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tccw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import tccw_pkg::*;

	localparam int SCR_COLS  = COLUMNS_DEF;
	localparam int SCR_ROWS  = ROWS_DEF;
	localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;
	localparam int RANDOM_WORDS = 1200;
	localparam int QUIET_AFTER  = 1000;

	// Screen and cursor shadow; queue of responses still owed by the block
	class screen_scoreboard;
		logic [CHAR_W-1:0] cells [SCR_CELLS];
		int cur_row;
		int cur_col;
		rsp_word_t owed [$];
		int errors;
		int n_writes;
		int n_reads;
		int n_newlines;
		int n_scrolls;
		int n_wraps;

		function new();
			foreach (cells[i]) cells[i] = '0;
			cur_row = 0;
			cur_col = 0;
			errors = 0;
			n_writes = 0;
			n_reads = 0;
			n_newlines = 0;
			n_scrolls = 0;
			n_wraps = 0;
		endfunction

		// Apply one accepted word to the shadow screen and queue its response
		function void note_request(req_word_t w);
			rsp_word_t r;
			r = '0;
			if (w.func == FUNC_READ) begin
				n_reads++;
				if (w.read_row < SCR_ROWS && w.read_col < SCR_COLS)
					r.read_char = cells[w.read_row * SCR_COLS + w.read_col];
			end else begin
				n_writes++;
				if (w.char_code != CHAR_NUL) begin
					// scroll first when the row index sits past the bottom
					if (cur_row >= SCR_ROWS) begin
						for (int i = 0; i < SCR_CELLS - SCR_COLS; i++)
							cells[i] = cells[i + SCR_COLS];
						for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
							cells[i] = '0;
						cur_row = SCR_ROWS - 1;
						r.scrolled = 1'b1;
						n_scrolls++;
					end
					if (w.char_code == CHAR_NEWLINE) begin
						cur_row++;
						cur_col = 0;
						n_newlines++;
					end else begin
						if (cur_col >= SCR_COLS)
							cur_col = 0;
						cells[cur_row * SCR_COLS + cur_col] = w.char_code;
						cur_col++;
						if (cur_col >= SCR_COLS) begin
							cur_row++;
							cur_col = 0;
							n_wraps++;
						end
						r.cursor_update = 1'b1;
					end
				end
				r.refresh_display = w.last_char;
			end
			r.cursor_pos = POS_W'(cur_row * SCR_COLS + cur_col);
			owed.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		// Compare one accepted response against the oldest owed word
		function void check_response(rsp_word_t got);
			rsp_word_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: response with none owed, expected nothing got %h",
					$time, got);
				return;
			end
			want = owed.pop_front();
			compare_field("cursor_update", want.cursor_update, got.cursor_update);
			compare_field("cursor_pos", want.cursor_pos, got.cursor_pos);
			compare_field("scrolled", want.scrolled, got.scrolled);
			compare_field("refresh_display", want.refresh_display, got.refresh_display);
			compare_field("read_char", want.read_char, got.read_char);
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	screen_scoreboard sb = new();
	bit idle_on;
	int gap_odds;
	int words_sent;

	text_console_char_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watch both handshakes
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			sb.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// Stall the response side in bursts, with quiet stretches in between
	initial begin
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if ($urandom_range(0, 31) == 0) begin
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
	end

	// Drive one word and hold it until accepted
	task automatic send_word(req_word_t w);
		if (idle_on && gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		words_sent++;
	endtask

	function automatic req_word_t make_write(logic [CHAR_W-1:0] c, logic last);
		req_word_t w;
		w = req_word_t'($urandom);
		w.func = FUNC_WRITE;
		w.char_code = c;
		w.last_char = last;
		return w;
	endfunction

	function automatic req_word_t make_read(int row, int col);
		req_word_t w;
		w = req_word_t'($urandom);
		w.func = FUNC_READ;
		w.read_row = RROW_W'(row);
		w.read_col = RCOL_W'(col);
		return w;
	endfunction

	// Pick a character for ordinary console text
	function automatic logic [CHAR_W-1:0] pick_char();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return CHAR_NEWLINE;
		if (roll < 20)
			return CHAR_NUL;
		return CHAR_W'($urandom_range(1, 255));
	endfunction

	// One write call of random text
	task automatic write_call(int len, bit no_newline);
		logic [CHAR_W-1:0] c;
		for (int i = 0; i < len; i++) begin
			c = no_newline ? CHAR_W'($urandom_range(11, 255)) : pick_char();
			send_word(make_write(c, i == len - 1));
		end
	endtask

	// Reads aimed near the cursor row, where the text lives, with some anywhere in the field range
	task automatic read_burst(int count);
		int row;
		for (int i = 0; i < count; i++) begin
			row = (sb.cur_row > SCR_ROWS - 1) ? SCR_ROWS - 1 : sb.cur_row;
			row = row - $urandom_range(0, 2);
			if (row < 0)
				row = 0;
			if ($urandom_range(0, 9) == 0)
				send_word(make_read($urandom_range(0, 31), $urandom_range(0, 127)));
			else
				send_word(make_read(row, $urandom_range(0, SCR_COLS - 1)));
		end
	endtask

	initial begin
		int pick;
		req_word_t w;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		idle_on = 1'b1;
		gap_odds = 20;
		words_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, blank reads, zero, newline, off-screen reads
		send_word(make_read(0, 0));
		send_word(make_write(8'h41, 1'b0));
		send_word(make_write(CHAR_NUL, 1'b1));
		send_word(make_write(CHAR_NEWLINE, 1'b0));
		send_word(make_write(8'hFF, 1'b1));
		send_word(make_write(8'h01, 1'b0));
		send_word(make_write(8'h80, 1'b0));
		send_word(make_write(8'h7F, 1'b1));
		send_word(make_read(1, 0));
		send_word(make_read(0, 0));
		send_word(make_read(1, 3));
		send_word(make_read(SCR_ROWS - 1, SCR_COLS - 1));
		send_word(make_read(SCR_ROWS, 0));
		send_word(make_read(0, SCR_COLS));
		send_word(make_read(31, 127));
		send_word(make_read(SCR_ROWS - 1, 127));
		w = make_read(0, 0);
		w.char_code = 8'hFF;
		w.last_char = 1'b1;
		send_word(w);
		send_word(make_write(CHAR_NEWLINE, 1'b1));
		send_word(make_write(CHAR_NUL, 1'b0));

		// Random: mostly write calls and nearby reads, some long lines and noise
		while (words_sent < RANDOM_WORDS) begin
			if (words_sent >= QUIET_AFTER)
				idle_on = 1'b0;
			gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 20;
			pick = $urandom_range(0, 99);
			if (pick < 55)
				write_call($urandom_range(1, 12), 1'b0);
			else if (pick < 62)
				write_call($urandom_range(70, 170), 1'b1);
			else if (pick < 90)
				read_burst($urandom_range(1, 6));
			else
				send_word(req_word_t'($urandom));
		end
		req_valid <= 1'b0;

		// Drain: everything owed has to come back, then watch for strays
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Ran %0d words: %0d writes (%0d newlines, %0d line wraps, %0d scrolls)",
			words_sent, sb.n_writes, sb.n_newlines, sb.n_wraps, sb.n_scrolls);
		$display("and %0d cell reads, with random gaps and stalls on both sides.",
			sb.n_reads);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("[text_console_char_writer] OK");
		end else begin
			$display("[text_console_char_writer] ERROR");
		end
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#2000000;
		$display("%0t: timeout with %0d responses owed", $time, sb.owed.size());
		$display("[text_console_char_writer] ERROR");
		$finish;
	end

endmodule
